// ===== design/bfcs_pkg.sv =====
package bfcs_pkg;

    localparam int PITCH_BITS_DEF  = 13;
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration port
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOFTLIN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RASTER  = 2'd3;

    localparam int ORIGIN_W = 11;
    localparam logic [CFG_DATA_W-1:0] PITCH_RESET  = 13'd1024;
    localparam logic [ORIGIN_W-1:0]   ORIGIN_RESET = 11'd0;
    localparam logic                  SOFTLIN_RESET = 1'b0;
    localparam logic                  RASTER_RESET  = 1'b1;

    // stream layout
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 6;

    // command codes
    localparam logic [2:0] CMD_BLIT   = 3'd0;
    localparam logic [2:0] CMD_TRANSP = 3'd1;
    localparam logic [2:0] CMD_FILL   = 3'd2;
    localparam logic [2:0] CMD_SPAN   = 3'd3;
    localparam logic [2:0] CMD_INVERT = 3'd4;

    // engine register selects
    localparam logic [3:0] SEL_CTRL    = 4'd0;
    localparam logic [3:0] SEL_SIGN    = 4'd1;
    localparam logic [3:0] SEL_START   = 4'd2;
    localparam logic [3:0] SEL_END     = 4'd3;
    localparam logic [3:0] SEL_STEP    = 4'd4;
    localparam logic [3:0] SEL_YDSTLEN = 4'd5;
    localparam logic [3:0] SEL_YDST    = 4'd6;
    localparam logic [3:0] SEL_LEN     = 4'd7;
    localparam logic [3:0] SEL_XB      = 4'd8;
    localparam logic [3:0] SEL_FG      = 4'd9;
    localparam logic [3:0] SEL_BG      = 4'd10;

    // control words
    localparam logic [31:0] GO_BLIT    = 32'h040c4018;
    localparam logic [31:0] GO_TRANSP  = 32'h440c4018;
    localparam logic [31:0] GO_RASTER  = 32'h400c7814;
    localparam logic [31:0] GO_BLOCK   = 32'h400c7844;
    localparam logic [31:0] GO_INVERT  = 32'h40057814;
    localparam logic [31:0] BG_TRANSP  = 32'hffffffff;

    // one classified command, ready for the write sequencer
    typedef struct packed {
        logic        is_blit;
        logic        transp;
        logic        lin_rows;
        logic        batch_end;
        logic [2:0]  sign;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [31:0] step;
        logic [31:0] ydstlen;
        logic [31:0] ydst;
        logic [31:0] len;
        logic [31:0] xbounds;
        logic [31:0] fgcol;
        logic [31:0] go_val;
    } job_t;

endpackage

// ===== design/blit_fill_command_setup_top.sv =====
// Drawing command front end: each request on the s_ side (one blit, transparent
// blit, rectangle fill, span fill or invert) becomes an ordered run of engine
// register writes on the m_ side, one write per cycle unless m_tready stalls it,
// with m_tlast and the go flag on the closing control write. A blit runs 8
// writes (9 with software linearisation), a transparent blit 10 or 11, a fill,
// span or invert 4 or 5; codes 5 to 7 produce nothing. The write sequencer
// loads the next queued command on the closing write, so back-to-back commands
// follow without a gap; once it has run dry, a load step comes before the first
// write. The first write is presented behind the front register (address
// multiplies), the two-entry command queue, the sequencer load and the output
// register. Configuration must be written only while idle; the block itself
// does not enforce this.
module blit_fill_command_setup_top #(
    parameter int PITCH_BITS  = bfcs_pkg::PITCH_BITS_DEF,
    parameter int QUEUE_DEPTH = bfcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x_first, y_first, x_second, y_second, width, height, colour
    input  logic [bfcs_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic [bfcs_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // reg_value
    output logic [bfcs_pkg::M_TDATA_W-1:0]   m_tdata,
    // reg_select, go, batch_done
    output logic [bfcs_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [bfcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bfcs_pkg::*;

    localparam int EXT_W = CFG_DATA_W + PITCH_BITS;
    localparam logic [EXT_W-1:0] PITCH_RESET_EXT = EXT_W'(PITCH_RESET);

    logic [PITCH_BITS-1:0] pitch_reg, pitch_next;
    logic [ORIGIN_W-1:0]   origin_reg, origin_next;
    logic                  soft_reg, soft_next;
    logic                  raster_reg, raster_next;
    logic [EXT_W-1:0]      wdata_ext;

    logic q_in_valid, q_in_ready, q_out_valid, q_pop;
    job_t q_in_data, q_out_data;

    // pitch register follows the pitch width, wider or narrower than the port
    assign wdata_ext = EXT_W'(cfg_wdata);

    always_comb begin
        pitch_next  = pitch_reg;
        origin_next = origin_reg;
        soft_next   = soft_reg;
        raster_next = raster_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_PITCH:   pitch_next  = wdata_ext[PITCH_BITS-1:0];
                CFG_ORIGIN:  origin_next = cfg_wdata[ORIGIN_W-1:0];
                CFG_SOFTLIN: soft_next   = cfg_wdata[0];
                CFG_RASTER:  raster_next = cfg_wdata[0];
                default:     pitch_next  = pitch_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg  <= PITCH_RESET_EXT[PITCH_BITS-1:0];
            origin_reg <= ORIGIN_RESET;
            soft_reg   <= SOFTLIN_RESET;
            raster_reg <= RASTER_RESET;
        end else begin
            pitch_reg  <= pitch_next;
            origin_reg <= origin_next;
            soft_reg   <= soft_next;
            raster_reg <= raster_next;
        end
    end

    bfcs_front #(
        .PITCH_BITS(PITCH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .pitch       (pitch_reg),
        .origin      (origin_reg),
        .soft_linear (soft_reg),
        .force_raster(raster_reg),
        .q_valid     (q_in_valid),
        .q_ready     (q_in_ready),
        .q_data      (q_in_data)
    );

    bfcs_queue #(
        .WIDTH($bits(job_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_in_valid),
        .in_ready (q_in_ready),
        .in_data  (q_in_data),
        .out_valid(q_out_valid),
        .out_pop  (q_pop),
        .out_data (q_out_data)
    );

    bfcs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_out_valid),
        .q_pop   (q_pop),
        .q_data  (q_out_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== design/bfcs_front.sv =====
module bfcs_front #(
    parameter int PITCH_BITS = bfcs_pkg::PITCH_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // x_first, y_first, x_second, y_second, width, height, colour
    input  logic [bfcs_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [bfcs_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tlast,
    input  logic [PITCH_BITS-1:0]          pitch,
    input  logic [bfcs_pkg::ORIGIN_W-1:0]  origin,
    input  logic                           soft_linear,
    input  logic                           force_raster,
    output logic                           q_valid,
    input  logic                           q_ready,
    output bfcs_pkg::job_t                 q_data
);
    import bfcs_pkg::*;

    localparam int PW = PITCH_BITS + 17;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] col;
        logic        be;
        logic        down;
        logic        right;
        logic [16:0] row;
        logic [31:0] prod_top;
        logic [31:0] prod_bot;
        logic [31:0] prod_row;
    } stage_t;

    logic   valid_reg, valid_next;
    stage_t st_reg, st_next;
    logic   accept, drain;
    logic   in_blit, cmd_ok;
    logic [16:0] y1h, y2h;

    logic [31:0] ts, te, bs, bend, a_start, a_end;
    logic [31:0] len, ydstlen;
    logic        is_blit;
    job_t        job;

    // ---------------- capture and multiply ----------------
    always_comb begin
        st_next.cmd   = s_tuser;
        st_next.x1    = s_tdata[15:0];
        st_next.y1    = s_tdata[31:16];
        st_next.x2    = s_tdata[47:32];
        st_next.y2    = s_tdata[63:48];
        st_next.w     = s_tdata[79:64];
        st_next.h     = s_tdata[95:80];
        st_next.col   = s_tdata[127:96];
        st_next.be    = s_tlast;
        st_next.down  = st_next.y2 > st_next.y1;
        st_next.right = st_next.x2 > st_next.x1;
        in_blit       = (s_tuser == CMD_BLIT) || (s_tuser == CMD_TRANSP);
        y1h           = {1'b0, st_next.y1} + {1'b0, st_next.h};
        y2h           = {1'b0, st_next.y2} + {1'b0, st_next.h};
        if (in_blit) begin
            st_next.row = st_next.down ? y2h : {1'b0, st_next.y2};
        end else begin
            st_next.row = {1'b0, st_next.y1};
        end
        st_next.prod_top = 32'(PW'(pitch) * PW'(st_next.y1));
        st_next.prod_bot = 32'(PW'(pitch) * PW'(y1h));
        st_next.prod_row = 32'(PW'(pitch) * PW'(st_next.row));
    end

    // unknown commands leave the stage without a push
    assign cmd_ok   = st_reg.cmd <= CMD_INVERT;
    assign drain    = valid_reg && (q_ready || !cmd_ok);
    assign s_tready = !valid_reg || drain;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (drain) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= st_next;
        end
    end

    // ---------------- address and value build ----------------
    always_comb begin
        is_blit = (st_reg.cmd == CMD_BLIT) || (st_reg.cmd == CMD_TRANSP);
        ts      = 32'(st_reg.x1) + st_reg.prod_top + 32'(origin);
        te      = ts + 32'(st_reg.w);
        bs      = 32'(st_reg.x1) + st_reg.prod_bot + 32'(origin);
        bend    = bs + 32'(st_reg.w);
        a_start = st_reg.down ? bs : ts;
        a_end   = st_reg.down ? bend : te;
        if (st_reg.right) begin
            job.start_addr = a_end;
            job.end_addr   = a_start;
        end else begin
            job.start_addr = a_start;
            job.end_addr   = a_end;
        end
        job.step = st_reg.down ? (32'd0 - 32'(pitch)) : 32'(pitch);
        job.sign = {st_reg.down, 1'b0, st_reg.right};

        len        = 32'd1;
        job.fgcol  = st_reg.col;
        job.go_val = GO_BLIT;
        job.xbounds = {st_reg.x2 + 16'd1, st_reg.x1};
        unique case (st_reg.cmd)
            CMD_BLIT: begin
                len         = 32'(st_reg.h) + 32'd1;
                job.xbounds = {st_reg.x2 + st_reg.w, st_reg.x2};
                job.go_val  = GO_BLIT;
            end
            CMD_TRANSP: begin
                len         = 32'(st_reg.h) + 32'd1;
                job.xbounds = {st_reg.x2 + st_reg.w, st_reg.x2};
                job.go_val  = GO_TRANSP;
            end
            CMD_FILL: begin
                // bottom above top wraps as it stands
                len        = 32'(st_reg.y2) - 32'(st_reg.y1) + 32'd1;
                job.go_val = force_raster ? GO_RASTER : GO_BLOCK;
            end
            CMD_SPAN: begin
                len        = 32'd1;
                job.go_val = force_raster ? GO_RASTER : GO_BLOCK;
            end
            CMD_INVERT: begin
                len        = 32'(st_reg.y2) - 32'(st_reg.y1) + 32'd1;
                job.fgcol  = 32'd0;
                job.go_val = GO_INVERT;
            end
            default: begin
                len        = 32'd1;
                job.go_val = GO_BLIT;
            end
        endcase
        ydstlen       = {st_reg.row[15:0], 16'd0} | len;
        job.len       = len;
        job.ydstlen   = ydstlen;
        job.ydst      = st_reg.prod_row >> 5;
        job.is_blit   = is_blit;
        job.transp    = st_reg.cmd == CMD_TRANSP;
        job.lin_rows  = soft_linear;
        job.batch_end = st_reg.be;
    end

    assign q_valid = valid_reg && cmd_ok;
    assign q_data  = job;

endmodule

// ===== design/bfcs_queue.sv =====
module bfcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_pop,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != FULL_CNT;
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== design/bfcs_back.sv =====
module bfcs_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  bfcs_pkg::job_t                 q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // reg_value
    output logic [bfcs_pkg::M_TDATA_W-1:0] m_tdata,
    // reg_select, go, batch_done
    output logic [bfcs_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import bfcs_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_CTRL0   = 13'b0000000000010,
        ST_SIGN    = 13'b0000000000100,
        ST_START   = 13'b0000000001000,
        ST_END     = 13'b0000000010000,
        ST_STEP    = 13'b0000000100000,
        ST_YDSTLEN = 13'b0000001000000,
        ST_YDST    = 13'b0000010000000,
        ST_LEN     = 13'b0000100000000,
        ST_XB      = 13'b0001000000000,
        ST_FG      = 13'b0010000000000,
        ST_BG      = 13'b0100000000000,
        ST_GO      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic   valid_reg, valid_next;
    logic [M_TDATA_W-1:0] data_reg, data_next;
    logic [M_TUSER_W-1:0] user_reg, user_next;
    logic   last_reg, last_next;
    logic   adv, load;
    logic [3:0]  sel;
    logic [31:0] val;
    state_t rows_first, after_rows, first_of_new;

    assign adv = !valid_reg || m_tready;
    assign load = adv && q_valid && ((state_reg == ST_IDLE) || (state_reg == ST_GO));
    assign q_pop = load;

    assign rows_first   = job_reg.lin_rows ? ST_YDST : ST_YDSTLEN;
    assign after_rows   = job_reg.is_blit ? ST_XB : ST_FG;
    assign first_of_new = q_data.is_blit ? ST_CTRL0 : ST_XB;

    always_comb begin
        sel = SEL_CTRL;
        val = 32'd0;
        unique case (state_reg)
            ST_CTRL0:   begin sel = SEL_CTRL;    val = 32'd0;                 end
            ST_SIGN:    begin sel = SEL_SIGN;    val = 32'(job_reg.sign);     end
            ST_START:   begin sel = SEL_START;   val = job_reg.start_addr;    end
            ST_END:     begin sel = SEL_END;     val = job_reg.end_addr;      end
            ST_STEP:    begin sel = SEL_STEP;    val = job_reg.step;          end
            ST_YDSTLEN: begin sel = SEL_YDSTLEN; val = job_reg.ydstlen;       end
            ST_YDST:    begin sel = SEL_YDST;    val = job_reg.ydst;          end
            ST_LEN:     begin sel = SEL_LEN;     val = job_reg.len;           end
            ST_XB:      begin sel = SEL_XB;      val = job_reg.xbounds;       end
            ST_FG:      begin sel = SEL_FG;      val = job_reg.fgcol;         end
            ST_BG:      begin sel = SEL_BG;      val = BG_TRANSP;             end
            ST_GO:      begin sel = SEL_CTRL;    val = job_reg.go_val;        end
            default:    begin sel = SEL_CTRL;    val = 32'd0;                 end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (adv) begin
            valid_next = state_reg != ST_IDLE;
            data_next  = val;
            user_next  = {(state_reg == ST_GO) && job_reg.batch_end,
                          state_reg == ST_GO, sel};
            last_next  = state_reg == ST_GO;
            unique case (state_reg)
                ST_IDLE:    state_next = load ? first_of_new : ST_IDLE;
                ST_CTRL0:   state_next = ST_SIGN;
                ST_SIGN:    state_next = ST_START;
                ST_START:   state_next = ST_END;
                ST_END:     state_next = ST_STEP;
                ST_STEP:    state_next = rows_first;
                ST_YDSTLEN: state_next = after_rows;
                ST_YDST:    state_next = ST_LEN;
                ST_LEN:     state_next = after_rows;
                ST_XB: begin
                    if (!job_reg.is_blit) begin
                        state_next = rows_first;
                    end else if (job_reg.transp) begin
                        state_next = ST_FG;
                    end else begin
                        state_next = ST_GO;
                    end
                end
                ST_FG:      state_next = job_reg.is_blit ? ST_BG : ST_GO;
                ST_BG:      state_next = ST_GO;
                ST_GO:      state_next = load ? first_of_new : ST_IDLE;
                default:    state_next = ST_IDLE;
            endcase
            if (load) begin
                job_next = q_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== tb/tb_blit_fill_command_setup_top.sv =====
`timescale 1ns / 1ps

module tb_blit_fill_command_setup_top;
    import bfcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_CMD    = 150;
    localparam int QUIET_TAIL     = 40;
    localparam int PHASE_CMDS     = 57;
    localparam int END_CYCLES     = 20;

    // codes that the block must swallow without a write
    localparam logic [2:0] CMD_NONE_FIRST = 3'd5;
    localparam logic [2:0] CMD_NONE_MID   = 3'd6;
    localparam logic [2:0] CMD_NONE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] x_first;
        logic [15:0] y_first;
        logic [15:0] x_second;
        logic [15:0] y_second;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] colour;
        logic        batch_end;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]  sel;
        logic [31:0] value;
        logic        go;
        logic        last;
        logic        batch_done;
    } reg_write_t;

    typedef enum logic [1:0] {
        STEP_CMD,
        STEP_DRAIN,
        STEP_CFG
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        cmd_item_t             item;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
    } script_step_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    blit_fill_command_setup_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register file as the engine front end sees it
    logic [12:0] cur_pitch  = PITCH_RESET;
    logic [10:0] cur_origin = ORIGIN_RESET;
    logic        cur_soft   = SOFTLIN_RESET;
    logic        cur_raster = RASTER_RESET;

    script_step_t cmd_script[$];
    reg_write_t   exp_writes[$];
    cmd_item_t    offered_item;

    int  n_cmds_total = 0;
    int  cmds_in = 0;
    int  writes_checked = 0;
    int  cfg_writes = 0;
    int  err_cnt = 0;
    bit  rst_done = 1'b0;
    bit  in_fire = 1'b0;
    bit  offering = 1'b0;
    bit  drain_wait = 1'b0;
    bit  quiet = 1'b0;
    int  settle_cnt = 0;
    int  s_gap = 0;
    int  m_gap = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    int  idle_cycles = 0;
    script_step_t cur_step;
    logic valid_n;
    logic cfg_we_n;
    logic ready_n;

    task automatic push_write(input logic [3:0] sel, input logic [31:0] value);
        reg_write_t w;
        w.sel = sel;
        w.value = value;
        w.go = 1'b0;
        w.last = 1'b0;
        w.batch_done = 1'b0;
        exp_writes.push_back(w);
    endtask

    // row start and line count: packed word or linearised pair
    task automatic push_rows(input logic [31:0] pitch, input logic [31:0] row,
                             input logic [31:0] len);
        logic [31:0] lin;
        if (cur_soft) begin
            lin = row * pitch;
            push_write(SEL_YDST, lin >> 5);
            push_write(SEL_LEN, len);
        end else begin
            push_write(SEL_YDSTLEN, (row << 16) | len);
        end
    endtask

    task automatic predict_reg_writes(input cmd_item_t c);
        logic [31:0] x1, y1, x2, y2, w, h, pitch, org;
        logic [31:0] ts, te, bs, bend, a_start, a_end, swap, stp, row, len, xb, go_val;
        logic        down, right, known;
        reg_write_t  fin;
        x1 = 32'(c.x_first);
        y1 = 32'(c.y_first);
        x2 = 32'(c.x_second);
        y2 = 32'(c.y_second);
        w = 32'(c.width);
        h = 32'(c.height);
        pitch = 32'(cur_pitch);
        org = 32'(cur_origin);
        known = 1'b1;
        go_val = '0;
        case (c.cmd)
            CMD_BLIT, CMD_TRANSP: begin
                ts = x1 + pitch * y1 + org;
                te = ts + w;
                bs = x1 + pitch * (y1 + h) + org;
                bend = bs + w;
                down = y2 > y1;
                right = x2 > x1;
                // copy bottom-up when the destination lies below the source
                if (down) begin
                    a_start = bs;
                    a_end = bend;
                    stp = 32'd0 - pitch;
                    row = y2 + h;
                end else begin
                    a_start = ts;
                    a_end = te;
                    stp = pitch;
                    row = y2;
                end
                if (right) begin
                    swap = a_start;
                    a_start = a_end;
                    a_end = swap;
                end
                xb = x2 + w;
                xb = (xb << 16) | x2;
                push_write(SEL_CTRL, 32'd0);
                push_write(SEL_SIGN, {29'd0, down, 1'b0, right});
                push_write(SEL_START, a_start);
                push_write(SEL_END, a_end);
                push_write(SEL_STEP, stp);
                push_rows(pitch, row, h + 32'd1);
                push_write(SEL_XB, xb);
                if (c.cmd == CMD_TRANSP) begin
                    push_write(SEL_FG, c.colour);
                    push_write(SEL_BG, BG_TRANSP);
                    go_val = GO_TRANSP;
                end else begin
                    go_val = GO_BLIT;
                end
            end
            CMD_FILL, CMD_SPAN, CMD_INVERT: begin
                len = (c.cmd == CMD_SPAN) ? 32'd1 : (y2 - y1 + 32'd1);
                xb = x2 + 32'd1;
                xb = (xb << 16) | x1;
                push_write(SEL_XB, xb);
                push_rows(pitch, y1, len);
                if (c.cmd == CMD_INVERT) begin
                    push_write(SEL_FG, 32'd0);
                    go_val = GO_INVERT;
                end else begin
                    push_write(SEL_FG, c.colour);
                    go_val = cur_raster ? GO_RASTER : GO_BLOCK;
                end
            end
            default: begin
                known = 1'b0;
            end
        endcase
        if (known) begin
            push_write(SEL_CTRL, go_val);
            fin = exp_writes.pop_back();
            fin.go = 1'b1;
            fin.last = 1'b1;
            fin.batch_done = c.batch_end;
            exp_writes.push_back(fin);
        end
    endtask

    task automatic add_cmd(input logic [2:0] cmd, input logic [15:0] x1, input logic [15:0] y1,
                           input logic [15:0] x2, input logic [15:0] y2, input logic [15:0] w,
                           input logic [15:0] h, input logic [31:0] col, input logic be);
        script_step_t st;
        st = '0;
        st.kind = STEP_CMD;
        st.item.cmd = cmd;
        st.item.x_first = x1;
        st.item.y_first = y1;
        st.item.x_second = x2;
        st.item.y_second = y2;
        st.item.width = w;
        st.item.height = h;
        st.item.colour = col;
        st.item.batch_end = be;
        cmd_script.push_back(st);
        n_cmds_total++;
    endtask

    task automatic add_drain();
        script_step_t st;
        st = '0;
        st.kind = STEP_DRAIN;
        cmd_script.push_back(st);
    endtask

    task automatic add_settings(input logic [12:0] pitch, input logic [10:0] origin,
                                input logic lin_mode, input logic raster);
        script_step_t st;
        add_drain();
        st = '0;
        st.kind = STEP_CFG;
        st.idx = CFG_PITCH;
        st.data = pitch;
        cmd_script.push_back(st);
        st.idx = CFG_ORIGIN;
        st.data = 13'(origin);
        cmd_script.push_back(st);
        st.idx = CFG_SOFTLIN;
        st.data = 13'(lin_mode);
        cmd_script.push_back(st);
        st.idx = CFG_RASTER;
        st.data = 13'(raster);
        cmd_script.push_back(st);
    endtask

    // mostly small on-screen shapes with overlapping blits, some full-range noise
    task automatic add_random_cmd();
        logic [2:0]  cmd;
        logic [15:0] x1, y1, x2, y2, w, h;
        logic [31:0] col;
        logic        be;
        if ($urandom_range(0, 19) == 0)
            cmd = 3'($urandom_range(CMD_NONE_FIRST, CMD_NONE_LAST));
        else
            cmd = 3'($urandom_range(CMD_BLIT, CMD_INVERT));
        col = $urandom;
        be = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) begin
            x1 = 16'($urandom);
            y1 = 16'($urandom);
            x2 = 16'($urandom);
            y2 = 16'($urandom);
            w = 16'($urandom);
            h = 16'($urandom);
        end else begin
            x1 = 16'($urandom_range(0, 1023));
            y1 = 16'($urandom_range(0, 767));
            w = 16'($urandom_range(0, 127));
            h = 16'($urandom_range(0, 63));
            if (cmd == CMD_BLIT || cmd == CMD_TRANSP) begin
                x2 = x1 + 16'($urandom_range(0, 16)) - 16'd8;
                y2 = y1 + 16'($urandom_range(0, 16)) - 16'd8;
            end else begin
                x2 = x1 + 16'($urandom_range(0, 200));
                y2 = y1 + 16'($urandom_range(0, 100)) - 16'd10;
            end
        end
        add_cmd(cmd, x1, y1, x2, y2, w, h, col, be);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (in_fire)
            offering = 1'b0;
        valid_n = offering;
        cfg_we_n = 1'b0;
        if (rst_done && !offering) begin
            if (drain_wait) begin
                if (exp_writes.size() != 0)
                    settle_cnt = SETTLE_CYCLES;
                else if (settle_cnt > 0)
                    settle_cnt--;
                else
                    drain_wait = 1'b0;
            end else if (s_gap > 0) begin
                s_gap--;
            end else if (cmd_script.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    s_gap = $urandom_range(1, 14) - 1;
                end else begin
                    cur_step = cmd_script.pop_front();
                    case (cur_step.kind)
                        STEP_CMD: begin
                            offering = 1'b1;
                            valid_n = 1'b1;
                            offered_item = cur_step.item;
                            s_tdata <= {cur_step.item.colour, cur_step.item.height,
                                        cur_step.item.width, cur_step.item.y_second,
                                        cur_step.item.x_second, cur_step.item.y_first,
                                        cur_step.item.x_first};
                            s_tuser <= cur_step.item.cmd;
                            s_tlast <= cur_step.item.batch_end;
                        end
                        STEP_DRAIN: begin
                            drain_wait = 1'b1;
                            settle_cnt = SETTLE_CYCLES;
                        end
                        STEP_CFG: begin
                            cfg_we_n = 1'b1;
                            cfg_index <= cur_step.idx;
                            cfg_wdata <= cur_step.data;
                            cfg_writes++;
                            case (cur_step.idx)
                                CFG_PITCH:   cur_pitch = cur_step.data[12:0];
                                CFG_ORIGIN:  cur_origin = cur_step.data[10:0];
                                CFG_SOFTLIN: cur_soft = cur_step.data[0];
                                CFG_RASTER:  cur_raster = cur_step.data[0];
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        s_tvalid <= valid_n;
        cfg_we <= cfg_we_n;
    end

    // write receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!rst_done) begin
            ready_n = 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            ready_n = 1'b0;
        end else if (!hold_done && cmds_in >= HOLD_AT_CMD) begin
            hold_done = 1'b1;
            hold_cnt = LONG_HOLD - 1;
            ready_n = 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            ready_n = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_gap = $urandom_range(1, 14) - 1;
            ready_n = 1'b0;
        end else begin
            ready_n = 1'b1;
        end
        m_tready <= ready_n;
    end

    // acceptance, prediction and checking
    always @(posedge aclk) begin
        if (aresetn) begin
            in_fire = s_tvalid && s_tready;
            if (in_fire) begin
                predict_reg_writes(offered_item);
                cmds_in++;
                quiet = (cmds_in >= n_cmds_total - QUIET_TAIL);
            end
            if (m_tvalid && m_tready) begin
                if (exp_writes.size() == 0) begin
                    $error("unexpected write: reg_select %0d reg_value %h",
                           m_tuser[3:0], m_tdata);
                    err_cnt++;
                end else begin
                    reg_write_t e;
                    e = exp_writes.pop_front();
                    writes_checked++;
                    if (m_tuser[3:0] !== e.sel) begin
                        $error("reg_select: expected %0d, got %0d", e.sel, m_tuser[3:0]);
                        err_cnt++;
                    end
                    if (m_tdata !== e.value) begin
                        $error("reg_value: expected %h, got %h", e.value, m_tdata);
                        err_cnt++;
                    end
                    if (m_tuser[4] !== e.go) begin
                        $error("go: expected %0b, got %0b", e.go, m_tuser[4]);
                        err_cnt++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last: expected %0b, got %0b", e.last, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser[5] !== e.batch_done) begin
                        $error("batch_done: expected %0b, got %0b", e.batch_done, m_tuser[5]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d of %0d requests in, %0d writes pending",
                     cmds_in, n_cmds_total, exp_writes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // directed part under reset settings
        add_cmd(CMD_BLIT, 16'd10, 16'd20, 16'd10, 16'd20, 16'd0, 16'd0, 32'd0, 1'b0);
        add_cmd(CMD_BLIT, 16'd100, 16'd50, 16'd104, 16'd53, 16'd64, 16'd15, 32'd0, 1'b0);
        add_cmd(CMD_BLIT, 16'd100, 16'd50, 16'd96, 16'd60, 16'd32, 16'd7, 32'd0, 1'b1);
        add_cmd(CMD_BLIT, 16'd100, 16'd50, 16'd120, 16'd40, 16'd32, 16'd7, 32'd0, 1'b0);
        add_cmd(CMD_BLIT, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                32'hffffffff, 1'b1);
        add_cmd(CMD_BLIT, 16'd0, 16'd0, 16'd1, 16'd1, 16'hffff, 16'hffff, 32'd0, 1'b0);
        add_cmd(CMD_TRANSP, 16'd5, 16'd5, 16'd9, 16'd8, 16'd20, 16'd3, 32'hffffffff, 1'b0);
        add_cmd(CMD_TRANSP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1);
        add_cmd(CMD_TRANSP, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff, 16'hffff,
                32'h5a5aa5a5, 1'b0);
        add_cmd(CMD_FILL, 16'd10, 16'd20, 16'd110, 16'd70, 16'd0, 16'd0, 32'h00ff00ff, 1'b0);
        // bottom above top: wrapped line count
        add_cmd(CMD_FILL, 16'd10, 16'd70, 16'd110, 16'd20, 16'd0, 16'd0, 32'h12345678, 1'b1);
        add_cmd(CMD_FILL, 16'd30, 16'd30, 16'd30, 16'd30, 16'd0, 16'd0, 32'd0, 1'b0);
        add_cmd(CMD_FILL, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                32'hffffffff, 1'b0);
        add_cmd(CMD_SPAN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0);
        add_cmd(CMD_SPAN, 16'd3, 16'hffff, 16'hffff, 16'h1234, 16'd0, 16'd0, 32'hdeadbeef, 1'b1);
        add_cmd(CMD_INVERT, 16'd8, 16'd9, 16'd40, 16'd50, 16'd0, 16'd0, 32'hffffffff, 1'b0);
        add_cmd(CMD_INVERT, 16'd8, 16'd50, 16'd40, 16'd9, 16'd0, 16'd0, 32'd0, 1'b1);
        add_cmd(CMD_NONE_FIRST, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 32'd7, 1'b1);
        add_cmd(CMD_NONE_MID, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                32'hffffffff, 1'b0);
        add_cmd(CMD_NONE_LAST, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1);
        add_cmd(CMD_BLIT, 16'd7, 16'd7, 16'd7, 16'd7, 16'd1, 16'd1, 32'd0, 1'b1);

        // random phases across register settings, extremes first
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: add_settings(13'd8191, 11'd2047, 1'b1, 1'b0);
                1: add_settings(13'd0, 11'd0, 1'b0, 1'b1);
                2: add_settings(13'd1, 11'd1024, 1'b1, 1'b1);
                3: add_settings(13'd1024, 11'd0, 1'b0, 1'b0);
                default: add_settings(13'($urandom_range(1, 8191)),
                                      11'($urandom_range(0, 1024)),
                                      1'($urandom), 1'($urandom));
            endcase
            for (int i = 0; i < PHASE_CMDS; i++) begin
                // sender waits for the block to run dry halfway through each phase but the last
                if (i == PHASE_CMDS / 2 && ph != 6)
                    add_drain();
                add_random_cmd();
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rst_done = 1'b1;

        wait (cmds_in == n_cmds_total && exp_writes.size() == 0);
        repeat (END_CYCLES) @(posedge aclk);
        if (exp_writes.size() != 0) begin
            $error("%0d expected writes never arrived", exp_writes.size());
            err_cnt++;
        end
        $display("covered %0d commands over 8 register settings (%0d config writes)",
                 n_cmds_total, cfg_writes);
        $display("checked %0d engine writes, %0d mismatches", writes_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bfcs_pkg.sv
design/bfcs_front.sv
design/bfcs_queue.sv
design/bfcs_back.sv
design/blit_fill_command_setup_top.sv
tb/tb_blit_fill_command_setup_top.sv
